// File: design/tlpw_pkg.sv
// shared types and constants for the two-level page walk
package tlpw_pkg;

    localparam int PAGE_COUNT_DEFAULT = 128;
    localparam int PAGE_BYTES         = 32;
    localparam int OFFSET_W           = 5;
    localparam int FRAME_W            = 7;
    localparam int BYTE_ADDR_W        = 12;
    localparam int VADDR_W            = 15;

    localparam logic [1:0] OP_WRITE_PHYS = 2'd0;
    localparam logic [1:0] OP_WRITE_DISK = 2'd1;
    localparam logic [1:0] OP_TRANSLATE  = 2'd2;

    localparam logic [1:0] ST_HIT   = 2'd0;
    localparam logic [1:0] ST_DISK  = 2'd1;
    localparam logic [1:0] ST_FAULT = 2'd2;
    localparam logic [1:0] ST_WRITE = 2'd3;

    typedef struct packed {
        logic start;
        logic walk_tab;
        logic walk_data;
        logic finish;
    } tlpw_cmd_t;

    typedef struct packed {
        logic translate;
        logic dir_valid;
    } tlpw_stat_t;

endpackage

// File: design/tlpw_ctrl.sv
// sequencer for request intake, walk steps and result handoff
module tlpw_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  tlpw_pkg::tlpw_stat_t stat,
    output tlpw_pkg::tlpw_cmd_t  cmd
);
    import tlpw_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_TAB  = 4'b0010,
        S_DATA = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = stat.translate ? S_TAB : S_FIN;
                end
            end
            S_TAB:
            begin
                cmd.walk_tab = 1'b1;
                state_next   = stat.dir_valid ? S_DATA : S_FIN;
            end
            S_DATA:
            begin
                cmd.walk_data = 1'b1;
                state_next    = S_FIN;
            end
            S_FIN:
            begin
                // hold the finished result until the output register frees up
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: design/tlpw_dpath.sv
// stores, base register, walk registers and result register
module tlpw_dpath #(
    parameter int PAGE_COUNT = tlpw_pkg::PAGE_COUNT_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  config_write,
    input  logic [11:0]           config_data,
    input  logic [1:0]            operation,
    input  logic [11:0]           store_address,
    input  logic [7:0]            store_data,
    input  logic [14:0]           virt_addr,
    input  tlpw_pkg::tlpw_cmd_t   cmd,
    output tlpw_pkg::tlpw_stat_t  stat,
    output logic [1:0]            status,
    output logic [4:0]            directory_index,
    output logic                  directory_valid,
    output logic [6:0]            directory_frame,
    output logic [4:0]            table_index,
    output logic                  table_valid,
    output logic [6:0]            table_frame,
    output logic [11:0]           target_address,
    output logic [7:0]            target_value
);
    import tlpw_pkg::*;

    localparam int         MEM_DEPTH  = PAGE_COUNT * PAGE_BYTES;
    localparam int         MEM_AW     = $clog2(MEM_DEPTH);
    localparam logic [7:0] PAGE_LIMIT = 8'(PAGE_COUNT);

    logic [7:0] phys_mem [0:MEM_DEPTH-1];
    logic [7:0] disk_mem [0:MEM_DEPTH-1];

    logic [11:0] dir_base_reg;
    logic [14:0] va_reg;
    logic        translate_reg;
    logic [7:0]  dent_reg;
    logic [7:0]  tent_reg;
    logic [7:0]  phys_q_reg;
    logic [7:0]  disk_q_reg;
    logic        rd_ok_reg;

    logic [1:0]  status_reg;
    logic [4:0]  dir_index_reg;
    logic        dir_valid_reg;
    logic [6:0]  dir_frame_reg;
    logic [4:0]  tab_index_reg;
    logic        tab_valid_reg;
    logic [6:0]  tab_frame_reg;
    logic [11:0] target_addr_reg;
    logic [7:0]  target_value_reg;

    logic [11:0] rd_addr;
    logic        rd_en;
    logic        rd_in_store;
    logic        wr_in_store;
    logic        phys_we;
    logic        disk_we;
    logic [7:0]  entry;
    logic [11:0] data_addr;
    logic [7:0]  data_value;

    function automatic logic in_store(input logic [11:0] addr);
        in_store = ({1'b0, addr[11:5]} < PAGE_LIMIT);
    endfunction

    // entry byte read last step, zero when it fell outside the store
    assign entry = rd_ok_reg ? phys_q_reg : 8'd0;

    assign stat.translate = (operation == OP_TRANSLATE);
    assign stat.dir_valid = entry[7];

    always_comb
    begin
        priority if (cmd.start)
            rd_addr = {dir_base_reg[11:5], virt_addr[14:10]};
        else if (cmd.walk_tab)
            rd_addr = {entry[6:0], va_reg[9:5]};
        else
            rd_addr = {entry[6:0], va_reg[4:0]};
    end

    assign rd_en       = (cmd.start && stat.translate) || cmd.walk_tab || cmd.walk_data;
    assign rd_in_store = in_store(rd_addr);
    assign wr_in_store = in_store(store_address);
    assign phys_we     = cmd.start && (operation == OP_WRITE_PHYS) && wr_in_store;
    assign disk_we     = cmd.start && (operation == OP_WRITE_DISK) && wr_in_store;

    always_ff @(posedge clk)
    begin
        if (phys_we)
            phys_mem[store_address[MEM_AW-1:0]] <= store_data;
        if (rd_en && rd_in_store)
            phys_q_reg <= phys_mem[rd_addr[MEM_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (disk_we)
            disk_mem[store_address[MEM_AW-1:0]] <= store_data;
        if (cmd.walk_data && rd_in_store)
            disk_q_reg <= disk_mem[rd_addr[MEM_AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dir_base_reg <= '0;
        else if (config_write)
            dir_base_reg <= config_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_ok_reg <= rd_in_store;
        if (cmd.start)
        begin
            va_reg        <= virt_addr;
            translate_reg <= stat.translate;
        end
        if (cmd.walk_tab)
            dent_reg <= entry;
        if (cmd.walk_data)
            tent_reg <= entry;
    end

    assign data_addr  = {tent_reg[6:0], va_reg[4:0]};
    assign data_value = rd_ok_reg ? (tent_reg[7] ? phys_q_reg : disk_q_reg) : 8'd0;

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status_reg       <= ST_WRITE;
            dir_index_reg    <= '0;
            dir_valid_reg    <= 1'b0;
            dir_frame_reg    <= '0;
            tab_index_reg    <= '0;
            tab_valid_reg    <= 1'b0;
            tab_frame_reg    <= '0;
            target_addr_reg  <= '0;
            target_value_reg <= '0;
            if (translate_reg)
            begin
                dir_index_reg <= va_reg[14:10];
                dir_valid_reg <= dent_reg[7];
                dir_frame_reg <= dent_reg[6:0];
                tab_index_reg <= va_reg[9:5];
                if (!dent_reg[7])
                    status_reg <= ST_FAULT;
                else
                begin
                    status_reg       <= tent_reg[7] ? ST_HIT : ST_DISK;
                    tab_valid_reg    <= tent_reg[7];
                    tab_frame_reg    <= tent_reg[6:0];
                    target_addr_reg  <= data_addr;
                    target_value_reg <= data_value;
                end
            end
        end
    end

    assign status          = status_reg;
    assign directory_index = dir_index_reg;
    assign directory_valid = dir_valid_reg;
    assign directory_frame = dir_frame_reg;
    assign table_index     = tab_index_reg;
    assign table_valid     = tab_valid_reg;
    assign table_frame     = tab_frame_reg;
    assign target_address  = target_addr_reg;
    assign target_value    = target_value_reg;

endmodule

// File: design/two_level_page_walk.sv
// two-level page walk: top level joining sequencer and datapath
//
// input channel (in_valid/in_ready) carries one request: a byte write to
// physical memory or disk, or a translation of virt_addr. every
// request yields exactly one result on the output channel (out_valid/
// out_ready), in request order.
// a translation walks directory entry, table entry, then data byte, one
// synchronous read of the physical memory per step. a write goes straight
// to the finish state, a directory fault passes the table step, a full walk
// the table and data steps; loading the result frees the sequencer for the
// next request. the result sits in an output register, so a new request is
// accepted while an earlier result waits; if the receiver stalls further,
// the walk finishes and then holds until the output register is taken. the
// user must write directory_base through config_write/config_data only
// while idle; the block does not enforce this. reset clears the sequencer,
// the output valid and directory_base; the stores are not cleared and must
// be written before they are read.
module two_level_page_walk #(
    parameter int PAGE_COUNT = tlpw_pkg::PAGE_COUNT_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        config_write,
    input  logic [11:0] config_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [11:0] store_address,
    input  logic [7:0]  store_data,
    input  logic [14:0] virt_addr,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [4:0]  directory_index,
    output logic        directory_valid,
    output logic [6:0]  directory_frame,
    output logic [4:0]  table_index,
    output logic        table_valid,
    output logic [6:0]  table_frame,
    output logic [11:0] target_address,
    output logic [7:0]  target_value
);
    import tlpw_pkg::*;

    tlpw_cmd_t  cmd;
    tlpw_stat_t stat;

    tlpw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tlpw_dpath #(
        .PAGE_COUNT (PAGE_COUNT)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .config_write    (config_write),
        .config_data     (config_data),
        .operation       (operation),
        .store_address   (store_address),
        .store_data      (store_data),
        .virt_addr       (virt_addr),
        .cmd             (cmd),
        .stat            (stat),
        .status          (status),
        .directory_index (directory_index),
        .directory_valid (directory_valid),
        .directory_frame (directory_frame),
        .table_index     (table_index),
        .table_valid     (table_valid),
        .table_frame     (table_frame),
        .target_address  (target_address),
        .target_value    (target_value)
    );

`ifndef SYNTHESIS
    // a result is never loaded over one that has not been taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid || out_ready))
        else $error("result loaded over a pending result");

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while a walk is running");

    // walk steps never overlap
    a_steps_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.start, cmd.walk_tab, cmd.walk_data, cmd.finish}))
        else $error("overlapping walk steps");

    // write results carry no target
    a_write_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_WRITE) |-> (target_address == '0 && target_value == '0))
        else $error("write result carries a target");
`endif

endmodule
